// File: hw/rtl/srsc_pkg.sv
// Shared types, widths and codes of the shadow return stack checker.
package srsc_pkg;

  localparam int ADDR_W          = 64;
  localparam int LEN_W           = 4;
  localparam int TID_W           = 2;
  localparam int DISC_W          = 7;
  localparam int STATUS_W        = 2;
  localparam int THREADS_DEF     = 4;
  localparam int STACK_DEPTH_DEF = 64;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 2'd0,
    ST_MATCH     = 2'd1,
    ST_VIOLATION = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALL,
    S_POP,
    S_CMP,
    S_DIST,
    S_ABS,
    S_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] value;
    logic              borrow;
    logic              zero;
  } alu_res_t;

  function automatic logic [TID_W-1:0] tid_wrap(input logic [TID_W-1:0] t,
                                                input int unsigned threads);
    logic [TID_W-1:0] w;
    w = t;
    for (int i = 0; i < (1 << TID_W) - 1; i++) begin
      if (32'(w) >= threads) begin
        w = w - TID_W'(threads);
      end
    end
    return w;
  endfunction

endpackage

// File: hw/rtl/srsc_if.sv
// Request and response channel interfaces of the shadow return stack checker.
interface srsc_req_if;
  import srsc_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [TID_W-1:0]  thread_id;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  insn_length;
  modport source (output valid, func, thread_id, address, insn_length, input ready);
  modport sink (input valid, func, thread_id, address, insn_length, output ready);
endinterface

interface srsc_rsp_if;
  import srsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DISC_W-1:0]   discarded;
  logic [ADDR_W-1:0]   distance;
  modport source (output valid, status, discarded, distance, input ready);
  modport sink (input valid, status, discarded, distance, output ready);
endinterface

// File: hw/rtl/shadow_return_stack_checker.sv
// Shadow return stack checker: per-thread return stacks in one RAM, one shared adder.
//
// Usage: req carries one transaction per executed call or return (func, thread_id,
// address, insn_length); rsp returns exactly one transaction per request with
// status, discarded and distance. A thread_id at or above THREADS wraps modulo THREADS.
// The block takes one request at a time; req.ready is high only while it is idle.
// Steps from request acceptance to rsp.valid, with k entries examined:
//   call (push or overflow):     S_CALL, S_DONE
//   return matching entry k:     k x (S_POP, S_CMP), S_DONE
//   return violation, k entries: k x (S_POP, S_CMP), S_POP, S_DIST, [S_ABS,] S_DONE
// Each examined entry takes one RAM read (S_POP) and then one compare (S_CMP) in the
// shared add/subtract unit; the single, registered RAM read port sets that order.
// A finished result sits in the rsp output register; the next request is accepted
// while it waits, and the block holds in its final step until the register frees.
// Reset (rst, synchronous) empties all stacks and drops any pending response;
// RAM contents are not cleared and are never read before being written.
module shadow_return_stack_checker #(
  parameter int THREADS     = srsc_pkg::THREADS_DEF,
  parameter int STACK_DEPTH = srsc_pkg::STACK_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  srsc_req_if.sink   req,
  srsc_rsp_if.source rsp
);
  import srsc_pkg::*;

  localparam int TIDX_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int IDX_W     = $clog2(STACK_DEPTH);
  localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
  localparam int RAM_AW    = TIDX_W + IDX_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  state_t              state;
  state_t              state_next;
  logic [TIDX_W-1:0]   tid;
  logic [TIDX_W-1:0]   req_tid;
  logic [ADDR_W-1:0]   target;
  logic [LEN_W-1:0]    len;
  logic [FILL_W-1:0]   cnt;
  logic [FILL_W-1:0]   cnt_dec;
  logic [DISC_W-1:0]   popped;
  logic [ADDR_W-1:0]   last;
  logic [ADDR_W-1:0]   abs_diff;
  status_t             res_status;
  logic [FILL_W-1:0]   fill [THREADS];
  logic                full;

  alu_op_t             alu_op;
  logic [ADDR_W-1:0]   alu_a;
  logic [ADDR_W-1:0]   alu_b;
  alu_res_t            alu_res;

  logic                ram_we;
  logic                ram_re;
  logic [RAM_AW-1:0]   ram_waddr;
  logic [RAM_AW-1:0]   ram_raddr;
  logic [ADDR_W-1:0]   ram_rdata;
  logic                out_free;

  assign req_tid   = TIDX_W'(tid_wrap(req.thread_id, THREADS));
  assign cnt_dec   = cnt - FILL_W'(1);
  assign full      = (cnt == FILL_W'(STACK_DEPTH));
  assign ram_waddr = {tid, cnt[IDX_W-1:0]};
  assign ram_raddr = {tid, cnt_dec[IDX_W-1:0]};
  assign out_free  = !rsp.valid || rsp.ready;

  srsc_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  srsc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (alu_res.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = req.func ? S_POP : S_CALL;
        end
      end
      S_CALL: state_next = S_DONE;
      S_POP: begin
        state_next = (cnt == '0) ? S_DIST : S_CMP;
      end
      S_CMP: begin
        state_next = alu_res.zero ? S_DONE : S_POP;
      end
      S_DIST: begin
        state_next = alu_res.borrow ? S_ABS : S_DONE;
      end
      S_ABS: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    alu_op    = ALU_SUB;
    alu_a     = last;
    alu_b     = target;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    case (state)
      S_IDLE: req.ready = 1'b1;
      S_CALL: begin
        alu_op = ALU_ADD;
        alu_a  = target;
        alu_b  = {{(ADDR_W - LEN_W){1'b0}}, len};
        ram_we = !full;
      end
      S_POP: ram_re = (cnt != '0);
      S_CMP: alu_a = ram_rdata;
      S_DIST: begin
        alu_a = last;
        alu_b = target;
      end
      S_ABS: begin
        alu_a = target;
        alu_b = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            tid      <= req_tid;
            target   <= req.address;
            len      <= req.insn_length;
            cnt      <= fill[req_tid];
            popped   <= '0;
            last     <= '0;
            abs_diff <= '0;
          end
        end
        S_CALL: begin
          if (full) begin
            res_status <= ST_OVERFLOW;
          end else begin
            fill[tid]  <= cnt + FILL_W'(1);
            res_status <= ST_PUSHED;
          end
        end
        S_POP: begin
          if (cnt != '0) begin
            cnt    <= cnt_dec;
            popped <= popped + DISC_W'(1);
          end
        end
        S_CMP: begin
          last <= ram_rdata;
          if (alu_res.zero) begin
            fill[tid]  <= cnt;
            res_status <= ST_MATCH;
          end
        end
        S_DIST: begin
          fill[tid]  <= '0;
          res_status <= ST_VIOLATION;
          abs_diff   <= alu_res.value;
        end
        S_ABS: abs_diff <= alu_res.value;
        S_DONE: begin
          if (out_free) begin
            rsp.status    <= res_status;
            rsp.discarded <= popped;
            rsp.distance  <= abs_diff;
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> cnt <= FILL_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_call_no_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_CALL |-> popped == '0)
    else $error("call transaction with popped entries");

  a_violation_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_DIST |-> cnt == '0)
    else $error("violation reported with entries left");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_DONE)
    else $error("response raised outside final step");

  a_distance_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_VIOLATION |-> rsp.distance == '0)
    else $error("nonzero distance without violation");

endmodule

// File: hw/rtl/srsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/srsc_alu.sv
// Shared 64-bit add/subtract unit with borrow and zero flags.
module srsc_alu (
  input  srsc_pkg::alu_op_t               op,
  input  logic [srsc_pkg::ADDR_W-1:0]     a,
  input  logic [srsc_pkg::ADDR_W-1:0]     b,
  output srsc_pkg::alu_res_t              res
);
  import srsc_pkg::*;

  logic [ADDR_W:0] wide;

  always_comb begin
    if (op == ALU_ADD) begin
      wide = {1'b0, a} + {1'b0, b};
    end else begin
      wide = {1'b0, a} - {1'b0, b};
    end
    res.value  = wide[ADDR_W-1:0];
    res.borrow = wide[ADDR_W];
    res.zero   = (wide[ADDR_W-1:0] == '0);
  end

endmodule
